[rtl/bmm_pkg.sv]
// ----------------------------------------------------------------------------
// bmm_pkg
// shared types and constants of the banked memory mapper
// ----------------------------------------------------------------------------
package bmm_pkg;

    localparam int DICT_PAGES    = 48;
    localparam int RAMDISK_PAGES = 88;

    localparam logic [7:0] CARD_SELECT_ON = 8'h82;
    localparam logic [7:0] IO_UNKNOWN     = 8'hff;

    typedef enum logic [1:0] {
        OP_MEM_READ  = 2'd0,
        OP_MEM_WRITE = 2'd1,
        OP_IO_READ   = 2'd2,
        OP_IO_WRITE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        RG_NONE    = 4'd0,
        RG_RAM     = 4'd1,
        RG_VRAM    = 4'd2,
        RG_EMS     = 4'd3,
        RG_LEARN   = 4'd4,
        RG_DICT    = 4'd5,
        RG_KANJI   = 4'd6,
        RG_CARD    = 4'd7,
        RG_RAMDISK = 4'd8,
        RG_ROMDISK = 4'd9,
        RG_IPL     = 4'd10
    } t_region;

    localparam logic [15:0] PORT_LEARN      = 16'h0c10;
    localparam logic [15:0] PORT_RAMDISK    = 16'h0e8e;
    localparam logic [15:0] PORT_RAMDISK_ST = 16'h0f8e;
    localparam logic [15:0] PORT_CARD       = 16'h1e8e;
    localparam logic [15:0] PORT_CARD_ST    = 16'h1f8e;
    localparam logic [15:0] PORT_DICT       = 16'h4c10;
    localparam logic [15:0] PORT_DICT_ST    = 16'h8810;
    localparam logic [15:0] PORT_KANJI      = 16'h8c10;
    localparam logic [15:0] PORT_ROMDISK_ST = 16'hc810;
    localparam logic [15:0] PORT_ROMDISK    = 16'hcc10;

    localparam logic [7:0] LEARN_FLAG      = 8'h40;
    localparam logic [7:0] RAMDISK_STATUS  = 8'h04;
    localparam logic [7:0] CARD_STATUS     = 8'h00;
    localparam logic [7:0] DICT_STATUS     = 8'h40;
    localparam logic [7:0] ROMDISK_STATUS  = 8'h10;

endpackage

[rtl/bmm_if.sv]
// ----------------------------------------------------------------------------
// bmm_if
// request and result channels of the banked memory mapper
// ----------------------------------------------------------------------------
interface bmm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [19:0] address;
    logic [7:0]  data;

    modport source (output valid, output operation, output address, output data,
                    input ready);
    modport sink   (input valid, input operation, input address, input data,
                    output ready);
endinterface

interface bmm_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  region;
    logic [20:0] region_offset;
    logic [7:0]  io_read_data;

    modport source (output valid, output region, output region_offset,
                    output io_read_data, input ready);
    modport sink   (input valid, input region, input region_offset,
                    input io_read_data, output ready);
endinterface

[rtl/banked_memory_mapper_unit.sv]
// ----------------------------------------------------------------------------
// banked_memory_mapper_unit
// maps a bus address onto a region and offset through i/o loaded bank registers
// ----------------------------------------------------------------------------
// request path: input register, then decode into the result register
// throughput: one transaction per cycle while o_out.ready does not stall the
//   result register, set by the single decode stage
// reset: synchronous active low, clears all bank registers to zero and empties
//   both pipeline registers
// ----------------------------------------------------------------------------
module banked_memory_mapper_unit #(
    parameter int DICT_PAGES    = bmm_pkg::DICT_PAGES,
    parameter int RAMDISK_PAGES = bmm_pkg::RAMDISK_PAGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmm_in_if.sink        i_in,
    bmm_out_if.source     o_out
);

    localparam logic [6:0] DICT_LIMIT    = 7'(DICT_PAGES);
    localparam logic [7:0] RAMDISK_LIMIT = 8'(RAMDISK_PAGES);

    logic        r_s1_valid;
    logic [1:0]  r_s1_op;
    logic [19:0] r_s1_addr;
    logic [7:0]  r_s1_data;

    logic        r_out_valid;
    logic [3:0]  r_region;
    logic [20:0] r_offset;
    logic [7:0]  r_io_data;

    logic [3:0]  r_learn_page;
    logic [6:0]  r_ramdisk_page;
    logic [7:0]  r_card_select;
    logic [5:0]  r_dict_page;
    logic [3:0]  r_kanji_page;
    logic [3:0]  r_romdisk_page;

    logic        s1_advance;
    logic        is_write;
    logic [15:0] port;
    logic [13:0] low;
    bmm_pkg::t_region n_region;
    logic [20:0] n_offset;
    logic [7:0]  n_io_data;

    assign s1_advance  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_advance;

    assign is_write = (r_s1_op == bmm_pkg::OP_MEM_WRITE);
    assign port     = r_s1_addr[15:0];
    assign low      = r_s1_addr[13:0];

    // address decode
    always_comb begin
        n_region = bmm_pkg::RG_NONE;
        n_offset = '0;
        if (r_s1_op == bmm_pkg::OP_MEM_READ || r_s1_op == bmm_pkg::OP_MEM_WRITE) begin
            if (r_s1_addr[19:16] < 4'ha) begin
                n_region = bmm_pkg::RG_RAM;
                n_offset = {1'b0, r_s1_addr};
            end else if (r_s1_addr[19:15] == 5'b10101) begin
                n_region = bmm_pkg::RG_VRAM;
                n_offset = {6'd0, r_s1_addr[14:0]};
            end else if (r_s1_addr[19:16] == 4'hc) begin
                n_region = bmm_pkg::RG_EMS;
                n_offset = {5'd0, r_s1_addr[15:0]};
            end else if (r_s1_addr[19:16] == 4'hd) begin
                case (r_s1_addr[15:14])
                    2'd0: begin
                        n_region = bmm_pkg::RG_LEARN;
                        n_offset = {3'd0, r_learn_page, low};
                    end
                    2'd1: begin
                        if (!is_write && ({1'b0, r_dict_page} < DICT_LIMIT)) begin
                            n_region = bmm_pkg::RG_DICT;
                            n_offset = {1'b0, r_dict_page, low};
                        end
                    end
                    2'd2: begin
                        if (!is_write) begin
                            n_region = bmm_pkg::RG_KANJI;
                            n_offset = {3'd0, r_kanji_page, low};
                        end
                    end
                    default: begin
                        if (r_card_select == bmm_pkg::CARD_SELECT_ON) begin
                            n_region = bmm_pkg::RG_CARD;
                            n_offset = {7'd0, low};
                        end else if ({1'b0, r_ramdisk_page} < RAMDISK_LIMIT) begin
                            n_region = bmm_pkg::RG_RAMDISK;
                            n_offset = {r_ramdisk_page, low};
                        end
                    end
                endcase
            end else if (r_s1_addr[19:16] == 4'he) begin
                if (!is_write) begin
                    n_region = bmm_pkg::RG_ROMDISK;
                    n_offset = {1'b0, r_romdisk_page, r_s1_addr[15:0]};
                end
            end else if (r_s1_addr[19:16] == 4'hf) begin
                if (!is_write) begin
                    n_region = bmm_pkg::RG_IPL;
                    n_offset = {5'd0, r_s1_addr[15:0]};
                end
            end
        end
    end

    // i/o readback
    always_comb begin
        n_io_data = '0;
        if (r_s1_op == bmm_pkg::OP_IO_READ) begin
            unique case (port)
                bmm_pkg::PORT_LEARN:      n_io_data = {4'd0, r_learn_page} | bmm_pkg::LEARN_FLAG;
                bmm_pkg::PORT_RAMDISK:    n_io_data = {1'b0, r_ramdisk_page};
                bmm_pkg::PORT_RAMDISK_ST: n_io_data = bmm_pkg::RAMDISK_STATUS;
                bmm_pkg::PORT_CARD:       n_io_data = r_card_select;
                bmm_pkg::PORT_CARD_ST:    n_io_data = bmm_pkg::CARD_STATUS;
                bmm_pkg::PORT_DICT:       n_io_data = {2'd0, r_dict_page};
                bmm_pkg::PORT_DICT_ST:    n_io_data = bmm_pkg::DICT_STATUS;
                bmm_pkg::PORT_KANJI:      n_io_data = {4'd0, r_kanji_page};
                bmm_pkg::PORT_ROMDISK_ST: n_io_data = bmm_pkg::ROMDISK_STATUS;
                bmm_pkg::PORT_ROMDISK:    n_io_data = {4'd0, r_romdisk_page};
                default:                  n_io_data = bmm_pkg::IO_UNKNOWN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_learn_page   <= '0;
            r_ramdisk_page <= '0;
            r_card_select  <= '0;
            r_dict_page    <= '0;
            r_kanji_page   <= '0;
            r_romdisk_page <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_advance && r_s1_op == bmm_pkg::OP_IO_WRITE) begin
                case (port)
                    bmm_pkg::PORT_LEARN:   r_learn_page   <= r_s1_data[3:0];
                    bmm_pkg::PORT_RAMDISK: r_ramdisk_page <= r_s1_data[6:0];
                    bmm_pkg::PORT_CARD:    r_card_select  <= r_s1_data;
                    bmm_pkg::PORT_DICT:    r_dict_page    <= r_s1_data[5:0];
                    bmm_pkg::PORT_KANJI:   r_kanji_page   <= r_s1_data[3:0];
                    bmm_pkg::PORT_ROMDISK: r_romdisk_page <= r_s1_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_op   <= i_in.operation;
            r_s1_addr <= i_in.address;
            r_s1_data <= i_in.data;
        end
        if (s1_advance) begin
            r_region  <= n_region;
            r_offset  <= n_offset;
            r_io_data <= n_io_data;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.region        = r_region;
    assign o_out.region_offset = r_offset;
    assign o_out.io_read_data  = r_io_data;

    a_none_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_region == bmm_pkg::RG_NONE) |-> (r_offset == '0))
        else $error("unmapped result with nonzero offset");

    a_io_no_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_io_data != '0) |-> (r_region == bmm_pkg::RG_NONE))
        else $error("i/o readback with a memory region");

    a_learn_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_advance && r_s1_op == bmm_pkg::OP_IO_WRITE && port == bmm_pkg::PORT_LEARN)
        |=> (r_learn_page == $past(r_s1_data[3:0])))
        else $error("learn bank not loaded by i/o write");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid || !r_out_valid) |-> i_in.ready)
        else $error("request stalled with free pipeline slot");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the banked memory mapper translation, bank switching and i/o readback
// against a predictor kept in step with every accepted request transaction,
// under sender gaps, result stalls and a free-running phase
// ----------------------------------------------------------------------------
module testbench;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam logic [15:0] PORT_SPARE     = 16'hffff;
    localparam logic [15:0] PORT_ZERO      = 16'h0000;

    typedef struct packed {
        bmm_pkg::t_region region;
        logic [20:0]      offset;
        logic [7:0]       io_data;
    } t_translation;

    logic clk;
    logic rst_n;

    bmm_in_if  in_ch ();
    bmm_out_if out_ch ();

    banked_memory_mapper_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [3:0] learn_page;
    logic [6:0] ramdisk_page;
    logic [7:0] card_select;
    logic [5:0] dict_page;
    logic [3:0] kanji_page;
    logic [3:0] romdisk_page;

    t_translation pending_translations[$];
    int mismatch_count;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_translation translate_request(input bmm_pkg::t_op op,
                                                       input logic [19:0] addr);
        t_translation r;
        logic         wr;
        logic [13:0]  low;
        r = '0;
        wr = (op == bmm_pkg::OP_MEM_WRITE);
        low = addr[13:0];
        if (op == bmm_pkg::OP_MEM_READ || op == bmm_pkg::OP_MEM_WRITE) begin
            if (addr < 20'ha0000) begin
                r.region = bmm_pkg::RG_RAM;
                r.offset = 21'(addr);
            end else if (addr >= 20'ha8000 && addr < 20'hb0000) begin
                r.region = bmm_pkg::RG_VRAM;
                r.offset = 21'(addr - 20'ha8000);
            end else if (addr >= 20'hc0000 && addr < 20'hd0000) begin
                r.region = bmm_pkg::RG_EMS;
                r.offset = 21'(addr - 20'hc0000);
            end else if (addr >= 20'hd0000 && addr < 20'hd4000) begin
                r.region = bmm_pkg::RG_LEARN;
                r.offset = 21'({learn_page, low});
            end else if (addr >= 20'hd4000 && addr < 20'hd8000) begin
                if (!wr && int'(dict_page) < bmm_pkg::DICT_PAGES) begin
                    r.region = bmm_pkg::RG_DICT;
                    r.offset = 21'({dict_page, low});
                end
            end else if (addr >= 20'hd8000 && addr < 20'hdc000) begin
                if (!wr) begin
                    r.region = bmm_pkg::RG_KANJI;
                    r.offset = 21'({kanji_page, low});
                end
            end else if (addr >= 20'hdc000 && addr < 20'he0000) begin
                if (card_select == bmm_pkg::CARD_SELECT_ON) begin
                    r.region = bmm_pkg::RG_CARD;
                    r.offset = 21'(low);
                end else if (int'(ramdisk_page) < bmm_pkg::RAMDISK_PAGES) begin
                    r.region = bmm_pkg::RG_RAMDISK;
                    r.offset = 21'({ramdisk_page, low});
                end
            end else if (addr >= 20'he0000 && addr < 20'hf0000) begin
                if (!wr) begin
                    r.region = bmm_pkg::RG_ROMDISK;
                    r.offset = 21'({romdisk_page, addr[15:0]});
                end
            end else if (addr >= 20'hf0000) begin
                if (!wr) begin
                    r.region = bmm_pkg::RG_IPL;
                    r.offset = 21'(addr - 20'hf0000);
                end
            end
            if (r.region == bmm_pkg::RG_NONE) begin
                r.offset = '0;
            end
        end else if (op == bmm_pkg::OP_IO_READ) begin
            case (addr[15:0])
                bmm_pkg::PORT_LEARN:      r.io_data = {4'b0, learn_page} | bmm_pkg::LEARN_FLAG;
                bmm_pkg::PORT_RAMDISK:    r.io_data = {1'b0, ramdisk_page};
                bmm_pkg::PORT_RAMDISK_ST: r.io_data = bmm_pkg::RAMDISK_STATUS;
                bmm_pkg::PORT_CARD:       r.io_data = card_select;
                bmm_pkg::PORT_CARD_ST:    r.io_data = bmm_pkg::CARD_STATUS;
                bmm_pkg::PORT_DICT:       r.io_data = {2'b0, dict_page};
                bmm_pkg::PORT_DICT_ST:    r.io_data = bmm_pkg::DICT_STATUS;
                bmm_pkg::PORT_KANJI:      r.io_data = {4'b0, kanji_page};
                bmm_pkg::PORT_ROMDISK_ST: r.io_data = bmm_pkg::ROMDISK_STATUS;
                bmm_pkg::PORT_ROMDISK:    r.io_data = {4'b0, romdisk_page};
                default:                  r.io_data = bmm_pkg::IO_UNKNOWN;
            endcase
        end
        return r;
    endfunction

    // predicts on request transactions, checks result transactions
    always @(posedge clk) begin : scoreboard
        t_translation want;
        if (!rst_n) begin
            learn_page   = '0;
            ramdisk_page = '0;
            card_select  = '0;
            dict_page    = '0;
            kanji_page   = '0;
            romdisk_page = '0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_translations.size() == 0) begin
                    $error("result transaction with nothing pending");
                    mismatch_count++;
                end else begin
                    want = pending_translations.pop_front();
                    if (out_ch.region !== want.region) begin
                        $error("region expected %0d actual %0d", want.region, out_ch.region);
                        mismatch_count++;
                    end
                    if (out_ch.region_offset !== want.offset) begin
                        $error("region_offset expected 0x%06h actual 0x%06h",
                               want.offset, out_ch.region_offset);
                        mismatch_count++;
                    end
                    if (out_ch.io_read_data !== want.io_data) begin
                        $error("io_read_data expected 0x%02h actual 0x%02h",
                               want.io_data, out_ch.io_read_data);
                        mismatch_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_translations.push_back(
                    translate_request(bmm_pkg::t_op'(in_ch.operation), in_ch.address));
                if (in_ch.operation == bmm_pkg::OP_IO_WRITE) begin
                    case (in_ch.address[15:0])
                        bmm_pkg::PORT_LEARN:   learn_page   = in_ch.data[3:0];
                        bmm_pkg::PORT_RAMDISK: ramdisk_page = in_ch.data[6:0];
                        bmm_pkg::PORT_CARD:    card_select  = in_ch.data;
                        bmm_pkg::PORT_DICT:    dict_page    = in_ch.data[5:0];
                        bmm_pkg::PORT_KANJI:   kanji_page   = in_ch.data[3:0];
                        bmm_pkg::PORT_ROMDISK: romdisk_page = in_ch.data[3:0];
                        default:      ;
                    endcase
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input bmm_pkg::t_op op, input logic [19:0] addr,
                             input logic [7:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.address   <= addr;
        in_ch.data      <= data;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_translations.size() != 0);
    endtask

    task automatic pick_request(output bmm_pkg::t_op op, output logic [19:0] addr,
                                output logic [7:0] data);
        logic [15:0] port;
        addr = 20'($urandom);
        data = 8'($urandom);
        if ($urandom_range(99) < 70) begin
            op = $urandom_range(1) ? bmm_pkg::OP_MEM_WRITE : bmm_pkg::OP_MEM_READ;
            // upper windows and gaps in 16k chunks, plain random for the rest
            if ($urandom_range(3) != 0) begin
                addr[19:14] = 6'($urandom_range(6'h28, 6'h3f));
            end
            case ($urandom_range(5))
                0:       addr[13:0] = '0;
                1:       addr[13:0] = '1;
                default: ;
            endcase
        end else begin
            op = $urandom_range(1) ? bmm_pkg::OP_IO_WRITE : bmm_pkg::OP_IO_READ;
            port = 16'($urandom);
            if ($urandom_range(9) != 0) begin
                case ($urandom_range(9))
                    0: port = bmm_pkg::PORT_LEARN;
                    1: port = bmm_pkg::PORT_RAMDISK;
                    2: port = bmm_pkg::PORT_RAMDISK_ST;
                    3: port = bmm_pkg::PORT_CARD;
                    4: port = bmm_pkg::PORT_CARD_ST;
                    5: port = bmm_pkg::PORT_DICT;
                    6: port = bmm_pkg::PORT_DICT_ST;
                    7: port = bmm_pkg::PORT_KANJI;
                    8: port = bmm_pkg::PORT_ROMDISK_ST;
                    default: port = bmm_pkg::PORT_ROMDISK;
                endcase
            end
            addr[15:0] = port;
            // bias bank values around the card code and the page limits
            case ($urandom_range(4))
                0:       data = bmm_pkg::CARD_SELECT_ON;
                1:       data = 8'($urandom_range(bmm_pkg::DICT_PAGES - 6,
                                                  bmm_pkg::DICT_PAGES + 6));
                2:       data = 8'($urandom_range(bmm_pkg::RAMDISK_PAGES - 6,
                                                  bmm_pkg::RAMDISK_PAGES + 6));
                default: ;
            endcase
        end
    endtask

    task automatic test_bank_readback();
        send_item(bmm_pkg::OP_IO_READ,  20'(bmm_pkg::PORT_LEARN),   8'h00);
        send_item(bmm_pkg::OP_IO_READ,  20'(bmm_pkg::PORT_CARD_ST), 8'h00);
        send_item(bmm_pkg::OP_IO_WRITE, 20'(bmm_pkg::PORT_LEARN),   8'hff);
        send_item(bmm_pkg::OP_IO_WRITE, 20'(bmm_pkg::PORT_DICT),    8'hff);
        send_item(bmm_pkg::OP_IO_WRITE, 20'(bmm_pkg::PORT_RAMDISK), 8'hff);
        send_item(bmm_pkg::OP_IO_WRITE, 20'(bmm_pkg::PORT_KANJI),   8'hff);
        send_item(bmm_pkg::OP_IO_WRITE, 20'(bmm_pkg::PORT_ROMDISK), 8'hff);
        send_item(bmm_pkg::OP_IO_WRITE, {4'hf, PORT_SPARE}, 8'hff);
        send_item(bmm_pkg::OP_IO_READ,  {4'hf, PORT_ZERO},  8'hff);
        send_item(bmm_pkg::OP_IO_READ,  20'(bmm_pkg::PORT_DICT),    8'h00);
    endtask

    task automatic test_window_map();
        send_item(bmm_pkg::OP_MEM_READ,  20'h00000, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'h9ffff, 8'hff);
        send_item(bmm_pkg::OP_MEM_READ,  20'ha0000, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'ha8000, 8'h55);
        send_item(bmm_pkg::OP_MEM_READ,  20'hcffff, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'hd3fff, 8'haa);
        send_item(bmm_pkg::OP_MEM_READ,  20'hd4000, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'hd8000, 8'h00);
        send_item(bmm_pkg::OP_MEM_READ,  20'hdbfff, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'hdffff, 8'h00);
        send_item(bmm_pkg::OP_MEM_READ,  20'heffff, 8'h00);
        send_item(bmm_pkg::OP_MEM_WRITE, 20'hfffff, 8'h00);
        send_item(bmm_pkg::OP_MEM_READ,  20'hfffff, 8'h00);
        // card select, then the last dictionary page in range
        send_item(bmm_pkg::OP_IO_WRITE,  20'(bmm_pkg::PORT_CARD), bmm_pkg::CARD_SELECT_ON);
        send_item(bmm_pkg::OP_IO_WRITE,  20'(bmm_pkg::PORT_DICT),
                  8'(bmm_pkg::DICT_PAGES - 1));
        send_item(bmm_pkg::OP_MEM_WRITE, 20'hdc000, 8'h00);
        send_item(bmm_pkg::OP_MEM_READ,  20'hd7fff, 8'h00);
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int stall_pct);
        bmm_pkg::t_op op;
        logic [19:0]  addr;
        logic [7:0]   data;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            pick_request(op, addr, data);
            send_item(op, addr, data);
            if ($urandom_range(99) == 0) begin
                wait_for_results();
            end
        end
        wait_for_results();
    endtask

    initial begin
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= bmm_pkg::OP_MEM_READ;
        in_ch.address   <= '0;
        in_ch.data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bank_readback();
        test_window_map();
        wait_for_results();
        test_random_traffic(530, 13, 51);
        test_random_traffic(530, 51, 13);
        test_random_traffic(530, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_translations.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
rtl/bmm_pkg.sv
rtl/bmm_if.sv
rtl/banked_memory_mapper_unit.sv
dv/testbench.sv
